// File: hdl/rmdd_pkg.sv
// Package for the running maximum drawdown tracker.
// Holds the widths, the drawdown scale, the controller states and a port helper.
// Depends on nothing.
package rmdd_pkg;

  localparam int unsigned EQUITY_BITS = 32;
  localparam int unsigned PORT_BITS   = 32;
  localparam int unsigned DD_BITS     = 14;
  localparam int unsigned DD_SCALE    = 10000;
  localparam int unsigned NUM_BITS    = EQUITY_BITS + DD_BITS;
  localparam int unsigned CNT_BITS    = $clog2(DD_BITS + 1);
  localparam int unsigned EXT_BITS    = EQUITY_BITS + PORT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } rmdd_state_e;

  // Fits an internal equity value onto a 32-bit port: zero extension or truncation.
  function automatic logic [PORT_BITS-1:0] to_port(input logic [EQUITY_BITS-1:0] v);
    logic [EXT_BITS-1:0] ext;
    ext = EXT_BITS'(v);
    return ext[PORT_BITS-1:0];
  endfunction

endpackage

// File: hdl/rmdd_div.sv
// Bit-serial restoring divider for the drawdown ratio, one quotient bit per cycle.
// The quotient is known to fit in DD_BITS bits, so the remainder stays below the divisor.
// Depends on rmdd_pkg.
module rmdd_div import rmdd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUM_BITS-1:0]    num_i,
  input  logic [EQUITY_BITS-1:0] den_i,
  output logic                   done_o,
  output logic [DD_BITS-1:0]     quo_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic [EQUITY_BITS-1:0] rem_q, rem_d;
  logic [DD_BITS-1:0]     low_q, low_d;
  logic [DD_BITS-1:0]     quo_q, quo_d;
  logic [EQUITY_BITS:0]   trial;
  logic [EQUITY_BITS:0]   diff;
  logic                   fits;

  assign trial = {rem_q, low_q[DD_BITS-1]};
  assign fits  = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(DD_BITS);
      rem_d  = num_i[NUM_BITS-1:DD_BITS];
      low_d  = num_i[DD_BITS-1:0];
      quo_d  = '0;
    end else if (busy_q) begin
      low_d = {low_q[DD_BITS-2:0], 1'b0};
      if (fits) begin
        rem_d = diff[EQUITY_BITS-1:0];
        quo_d = {quo_q[DD_BITS-2:0], 1'b1};
      end else begin
        rem_d = trial[EQUITY_BITS-1:0];
        quo_d = {quo_q[DD_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hdl/running_max_drawdown_tracker.sv
// Running maximum drawdown tracker: peak, trough and worst drawdown of an equity curve.
// A sample that needs no division shows its result in the next cycle; when a new trough
// forces the ratio, the result waits on the multiply state and the 14-step bit-serial divider.
// No new sample is taken while a division runs. Reset clears peak, trough and drawdown.
// Depends on rmdd_pkg and rmdd_div.
module running_max_drawdown_tracker import rmdd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PORT_BITS-1:0] equity_i,
  input  logic                 first_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DD_BITS-1:0]   worst_dd_o,
  output logic [PORT_BITS-1:0] peak_equity_o,
  output logic [PORT_BITS-1:0] trough_equity_o
);

  rmdd_state_e            state_q, state_d;
  logic [EQUITY_BITS-1:0] peak_q, peak_d;
  logic [EQUITY_BITS-1:0] trough_q, trough_d;
  logic [EQUITY_BITS-1:0] diff_q, diff_d;
  logic [DD_BITS-1:0]     worst_q, worst_d;
  logic                   out_valid_q, out_valid_d;
  logic [EQUITY_BITS-1:0] eq;
  logic                   accept;
  logic                   div_path;
  logic                   div_start;
  logic                   div_done;
  logic [DD_BITS-1:0]     div_quo;
  logic [NUM_BITS-1:0]    num;

  assign eq       = EQUITY_BITS'(equity_i);
  assign accept   = in_valid_i && in_ready_o;
  // A new trough below a nonzero peak is the only case that needs the ratio.
  assign div_path = !first_sample_i && (eq < peak_q) && (eq <= trough_q);
  assign num      = NUM_BITS'(diff_q) * NUM_BITS'(DD_SCALE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && div_path) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = !out_valid_q || out_ready_i;
      ST_MUL:  div_start  = 1'b1;
      ST_DIV:  ;
      default: ;
    endcase
  end

  always_comb begin
    peak_d   = peak_q;
    trough_d = trough_q;
    worst_d  = worst_q;
    diff_d   = diff_q;
    if (accept) begin
      if (first_sample_i) begin
        peak_d   = eq;
        trough_d = eq;
        worst_d  = '0;
      end else if (eq >= peak_q) begin
        peak_d   = eq;
        trough_d = eq;
      end else if (eq <= trough_q) begin
        trough_d = eq;
        diff_d   = peak_q - eq;
      end
    end
    if (div_done && (div_quo > worst_q)) begin
      worst_d = div_quo;
    end
  end

  // The result is shown straight from the state registers, which hold still until
  // the next transfer on the input side.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if ((accept && !div_path) || div_done) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      peak_q      <= '0;
      trough_q    <= '0;
      worst_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      trough_q    <= trough_d;
      worst_q     <= worst_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  rmdd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (peak_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_valid_o     = out_valid_q;
  assign worst_dd_o      = worst_q;
  assign peak_equity_o   = to_port(peak_q);
  assign trough_equity_o = to_port(trough_q);

`ifndef ASSERT_OFF
  a_valid_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == ST_IDLE)
    else $error("result pending while a division runs");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_trough_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trough_q <= peak_q)
    else $error("trough above peak");

  a_dd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    worst_q <= DD_BITS'(DD_SCALE))
    else $error("drawdown above full scale");
`endif

endmodule
